// ===== hdl/frame_completion_tracker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Frame completion tracker assertion macros
// Concurrent assertion forms used by the tracker back end.
// ----------------------------------------------------------------------------
`ifndef FRAME_COMPLETION_TRACKER_UNIT_ASSERT_SVH
`define FRAME_COMPLETION_TRACKER_UNIT_ASSERT_SVH

// invariant checked at every edge outside reset
`define FCT_ASSERT_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("frame completion tracker invariant violated");

// consequence checked in the cycle after the antecedent
`define FCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame completion tracker sequence violated");

`endif

// ===== hdl/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame completion tracker package
// Field widths, register indexes, item modes and internal command codes.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int COUNT_W         = 31;
    localparam int FRAME_W         = 31;
    localparam int MODE_W          = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 31;
    localparam int DEF_FRAME_SLOTS = 1024;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_REF   = 2'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_MARK  = 2'd0,
        MODE_START = 2'd1,
        MODE_END   = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    localparam int OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_MARK   = 3'd0,
        OP_START  = 3'd1,
        OP_END    = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_REJECT = 3'd4
    } t_op;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

// ===== hdl/fct_item_if.sv =====
// ----------------------------------------------------------------------------
// Frame completion tracker item channel
// Valid/ready channel carrying one tracker event.
// ----------------------------------------------------------------------------
interface fct_item_if;
    import fct_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [FRAME_W-1:0] frame_index;

    modport source (output valid, output mode, output frame_index, input ready);
    modport sink   (input valid, input mode, input frame_index, output ready);
endinterface

// ===== hdl/fct_result_if.sv =====
// ----------------------------------------------------------------------------
// Frame completion tracker result channel
// Valid/ready channel carrying counters and flags after each event.
// ----------------------------------------------------------------------------
interface fct_result_if;
    import fct_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] latest_count;
    logic [COUNT_W-1:0] complete_count;
    logic               in_progress;
    logic               index_error;

    modport source (output valid, output latest_count, output complete_count,
                    output in_progress, output index_error, input ready);
    modport sink   (input valid, input latest_count, input complete_count,
                    input in_progress, input index_error, output ready);
endinterface

// ===== hdl/fct_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Frame completion tracker configuration channel
// Valid/ready register write channel: index and data.
// ----------------------------------------------------------------------------
interface fct_cfg_if;
    import fct_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/frame_completion_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// Frame completion tracker
// Bitmap of written frames with latest and contiguous-complete counters.
// ----------------------------------------------------------------------------
// After reset the bitmap memory is cleared one entry per cycle; items are
// held off during that time while register writes are taken. Events pass a
// classifier into a queue of QUEUE_DEPTH entries (two by default), and the
// executor then handles one at a time from a bitmap memory with one write
// port and one read port: an end-series or rejected mark goes straight to
// the result register; a mark that leaves the contiguous prefix where it
// was passes the sum and compare steps; one that extends it first scans on
// over each further written frame, up to the end of the bitmap, before
// those steps; a start-series or clear sweeps the memory. Each event also
// waits while the previous result is still held in the result register.
// The queue and the result register let the next events be accepted while
// a result waits.
module frame_completion_tracker_unit #(
    parameter int FRAME_SLOTS = fct_pkg::DEF_FRAME_SLOTS,
    parameter int QUEUE_DEPTH = fct_pkg::DEF_QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fct_cfg_if.sink      i_cfg,
    fct_item_if.sink     i_item,
    fct_result_if.source o_result
);
    import fct_pkg::*;

    localparam int AW = $clog2(FRAME_SLOTS);
    localparam int QW = OP_W + AW;

    t_cfg_wr       cfg_wr;
    logic          init_busy;
    logic          push;
    logic          push_ready;
    t_op           push_op;
    logic [AW-1:0] push_pos;
    logic          pop_valid;
    logic          pop_ready;
    logic [QW-1:0] pop_data;

    assign i_cfg.ready  = 1'b1;
    assign cfg_wr.valid = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;

    fct_front #(
        .FRAME_SLOTS (FRAME_SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_cfg_wr     (cfg_wr),
        .i_init_busy  (init_busy),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_push_op    (push_op),
        .o_push_pos   (push_pos)
    );

    fct_queue #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  ({push_op, push_pos}),
        .o_push_ready (push_ready),
        .i_pop        (pop_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data)
    );

    fct_back #(
        .FRAME_SLOTS (FRAME_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (cfg_wr),
        .i_cmd_valid (pop_valid),
        .o_cmd_ready (pop_ready),
        .i_cmd_op    (t_op'(pop_data[QW-1:AW])),
        .i_cmd_pos   (pop_data[AW-1:0]),
        .o_init_busy (init_busy),
        .o_result    (o_result)
    );
endmodule

// ===== hdl/fct_queue.sv =====
// ----------------------------------------------------------------------------
// Frame completion tracker command queue
// Small circular FIFO between the classifier and the executor.
// ----------------------------------------------------------------------------
module fct_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_push_ready,
    input  logic              i_pop,
    output logic              o_pop_valid,
    output logic [DATA_W-1:0] o_pop_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] r_entry [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push_fire;
    logic              pop_fire;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_entry[r_rd_ptr];
    assign push_fire    = i_push && o_push_ready;
    assign pop_fire     = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_fire) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_fire) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_fire && !pop_fire) begin
                r_count <= r_count + 1'b1;
            end else if (pop_fire && !push_fire) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ===== hdl/fct_front.sv =====
// ----------------------------------------------------------------------------
// Frame completion tracker front end
// Accepts events, maps frame indexes to bitmap positions, flags bad ones.
// ----------------------------------------------------------------------------
module fct_front #(
    parameter int FRAME_SLOTS = fct_pkg::DEF_FRAME_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    fct_item_if.sink                         i_item,
    input  fct_pkg::t_cfg_wr                 i_cfg_wr,
    input  logic                             i_init_busy,
    output logic                             o_push,
    input  logic                             i_push_ready,
    output fct_pkg::t_op                     o_push_op,
    output logic [$clog2(FRAME_SLOTS)-1:0]   o_push_pos
);
    import fct_pkg::*;

    localparam int AW = $clog2(FRAME_SLOTS);
    localparam logic [FRAME_W-1:0] SLOTS_F = FRAME_W'(FRAME_SLOTS);

    logic [FRAME_W-1:0] r_ref_index;
    logic [FRAME_W:0]   diff;
    logic               reject;

    assign i_item.ready = i_push_ready && !i_init_busy;
    assign o_push       = i_item.valid && !i_init_busy;
    assign diff         = {1'b0, i_item.frame_index} - {1'b0, r_ref_index};
    assign reject       = diff[FRAME_W] || (diff[FRAME_W-1:0] >= SLOTS_F);
    assign o_push_pos   = diff[AW-1:0];

    always_comb begin
        unique case (t_mode'(i_item.mode))
            MODE_MARK:  o_push_op = reject ? OP_REJECT : OP_MARK;
            MODE_START: o_push_op = OP_START;
            MODE_END:   o_push_op = OP_END;
            MODE_CLEAR: o_push_op = OP_CLEAR;
            default:    o_push_op = OP_END;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_index <= '0;
        end else if (i_cfg_wr.valid && i_cfg_wr.index == CFG_IDX_REF) begin
            r_ref_index <= i_cfg_wr.data;
        end
    end
endmodule

// ===== hdl/fct_back.sv =====
// ----------------------------------------------------------------------------
// Frame completion tracker back end
// Owns the written bitmap memory, prefix scan, counters and result register.
// ----------------------------------------------------------------------------
module fct_back #(
    parameter int FRAME_SLOTS = fct_pkg::DEF_FRAME_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fct_pkg::t_cfg_wr               i_cfg_wr,
    input  logic                           i_cmd_valid,
    output logic                           o_cmd_ready,
    input  fct_pkg::t_op                   i_cmd_op,
    input  logic [$clog2(FRAME_SLOTS)-1:0] i_cmd_pos,
    output logic                           o_init_busy,
    fct_result_if.source                   o_result
);
    import fct_pkg::*;

    `include "frame_completion_tracker_unit_assert.svh"

    localparam int AW = $clog2(FRAME_SLOTS);
    localparam int PW = $clog2(FRAME_SLOTS + 1);
    localparam int SW = COUNT_W + 1;
    localparam logic [PW-1:0] SLOTS_P   = PW'(FRAME_SLOTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SUM,
        ST_CMP,
        ST_OUT
    } t_state;

    logic         r_mem [FRAME_SLOTS];
    logic         r_rdata;
    t_state       r_state;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_pos;
    logic [PW-1:0] r_prefix;
    logic [COUNT_W-1:0] r_start;
    logic [COUNT_W-1:0] r_latest;
    logic [COUNT_W-1:0] r_complete;
    logic [SW-1:0] r_sum_latest;
    logic [SW-1:0] r_sum_complete;
    logic          r_active;
    logic          r_err;
    logic          r_out_valid;
    logic [COUNT_W-1:0] r_out_latest;
    logic [COUNT_W-1:0] r_out_complete;
    logic          r_out_active;
    logic          r_out_err;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [COUNT_W-1:0] sat_latest;
    logic [COUNT_W-1:0] sat_complete;
    logic          out_free;
    logic          scan_hit;

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_init_busy = (r_state == ST_INIT);
    assign out_free    = !r_out_valid || o_result.ready;
    assign scan_hit    = (r_state == ST_SCAN_CHK) && r_rdata;

    assign o_result.valid          = r_out_valid;
    assign o_result.latest_count   = r_out_latest;
    assign o_result.complete_count = r_out_complete;
    assign o_result.in_progress    = r_out_active;
    assign o_result.index_error    = r_out_err;

    assign sat_latest   = r_sum_latest[COUNT_W] ? COUNT_MAX : r_sum_latest[COUNT_W-1:0];
    assign sat_complete = r_sum_complete[COUNT_W] ? COUNT_MAX
                                                  : r_sum_complete[COUNT_W-1:0];

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = 1'b0;
        if (r_state == ST_INIT || r_state == ST_SWEEP) begin
            mem_we = 1'b1;
        end else if (r_state == ST_IDLE && i_cmd_valid && i_cmd_op == OP_MARK) begin
            mem_we    = 1'b1;
            mem_waddr = i_cmd_pos;
            mem_wdata = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_prefix[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_addr      <= '0;
            r_prefix    <= '0;
            r_start     <= '0;
            r_latest    <= '0;
            r_complete  <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_result.ready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr.valid && i_cfg_wr.index == CFG_IDX_START) begin
                r_start    <= i_cfg_wr.data;
                r_latest   <= i_cfg_wr.data;
                r_complete <= i_cfg_wr.data;
            end
            unique case (r_state)
                ST_INIT: begin
                    if (r_addr == LAST_ADDR) begin
                        r_addr  <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_err <= 1'b0;
                        unique case (i_cmd_op) inside
                            OP_MARK: begin
                                r_pos <= i_cmd_pos;
                                if (PW'(i_cmd_pos) == r_prefix) begin
                                    r_prefix <= r_prefix + 1'b1;
                                    r_state  <= ST_SCAN_RD;
                                end else begin
                                    r_state <= ST_SUM;
                                end
                            end
                            OP_START, OP_CLEAR: begin
                                if (i_cmd_op == OP_START) begin
                                    r_active <= 1'b1;
                                end
                                r_addr   <= '0;
                                r_prefix <= '0;
                                r_state  <= ST_SWEEP;
                            end
                            OP_END: begin
                                r_active <= 1'b0;
                                r_state  <= ST_OUT;
                            end
                            OP_REJECT: begin
                                r_err   <= 1'b1;
                                r_state <= ST_OUT;
                            end
                            default: r_state <= ST_OUT;
                        endcase
                    end
                end
                ST_SWEEP: begin
                    if (r_addr == LAST_ADDR) begin
                        r_addr  <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_SCAN_RD: begin
                    r_state <= (r_prefix == SLOTS_P) ? ST_SUM : ST_SCAN_CHK;
                end
                ST_SCAN_CHK: begin
                    if (r_rdata) begin
                        r_prefix <= r_prefix + 1'b1;
                        r_state  <= ST_SCAN_RD;
                    end else begin
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_sum_latest   <= {1'b0, r_start} + SW'(r_pos) + 1'b1;
                    r_sum_complete <= {1'b0, r_start} + SW'(r_prefix);
                    r_state        <= ST_CMP;
                end
                ST_CMP: begin
                    if (sat_latest > r_latest) begin
                        r_latest <= sat_latest;
                    end
                    if (r_prefix != '0 && sat_complete > r_complete) begin
                        r_complete <= sat_complete;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_latest   <= r_latest;
                        r_out_complete <= r_complete;
                        r_out_active   <= r_active;
                        r_out_err      <= r_err;
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `FCT_ASSERT_HOLDS(a_complete_le_latest, i_clk, i_rst_n, r_complete <= r_latest)
    `FCT_ASSERT_HOLDS(a_prefix_bounded, i_clk, i_rst_n, r_prefix <= SLOTS_P)
    `FCT_ASSERT_NEXT(a_scan_advances, i_clk, i_rst_n, scan_hit, r_prefix == $past(r_prefix) + 1'b1)
endmodule

// ===== verif/frame_completion_tracker_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Frame completion tracker checker
// Watches the register, event and result channels. Keeps its own bitmap,
// prefix length, counters and series flag, predicts the status after every
// accepted event and compares each returned status field by field.
// ----------------------------------------------------------------------------
module frame_completion_tracker_unit_checker #(
    parameter int FRAME_SLOTS = fct_pkg::DEF_FRAME_SLOTS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    fct_cfg_if      i_cfg,
    fct_item_if     i_item,
    fct_result_if   i_result,
    output int      o_fail_count,
    output int      o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import fct_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] latest_count;
        logic [COUNT_W-1:0] complete_count;
        logic               in_progress;
        logic               index_error;
    } t_frame_status;

    bit                 frame_written [FRAME_SLOTS];
    int                 prefix_run;
    logic [COUNT_W-1:0] count_base;
    logic [FRAME_W-1:0] frame_base;
    logic [COUNT_W-1:0] latest_val;
    logic [COUNT_W-1:0] complete_val;
    logic               series_open;

    t_frame_status      due_status_q [$];
    t_frame_status      want;
    int                 mismatches = 0;

    function automatic logic [COUNT_W-1:0] capped_sum(logic [COUNT_W-1:0] base,
                                                      longint unsigned extra);
        longint unsigned total;
        total = base + extra;
        if (total > COUNT_MAX) begin
            return COUNT_MAX;
        end
        return total[COUNT_W-1:0];
    endfunction

    function automatic void wipe_map();
        foreach (frame_written[i]) begin
            frame_written[i] = 1'b0;
        end
        prefix_run = 0;
    endfunction

    function automatic t_frame_status track_event(t_mode mode, logic [FRAME_W-1:0] frame);
        t_frame_status      status;
        logic [FRAME_W-1:0] offset;
        logic [COUNT_W-1:0] cand;
        status.index_error = 1'b0;
        offset = frame - frame_base;
        case (mode)
            MODE_MARK: begin
                if (frame < frame_base || offset >= FRAME_SLOTS) begin
                    status.index_error = 1'b1;
                end else begin
                    frame_written[offset] = 1'b1;
                    cand = capped_sum(count_base, offset + 1);
                    if (cand > latest_val) begin
                        latest_val = cand;
                    end
                    while (prefix_run < FRAME_SLOTS && frame_written[prefix_run]) begin
                        prefix_run++;
                    end
                    if (prefix_run > 0) begin
                        cand = capped_sum(count_base, prefix_run);
                        if (cand > complete_val) begin
                            complete_val = cand;
                        end
                    end
                end
            end
            MODE_START: begin
                wipe_map();
                series_open = 1'b1;
            end
            MODE_END: begin
                series_open = 1'b0;
            end
            default: begin
                wipe_map();
            end
        endcase
        status.latest_count   = latest_val;
        status.complete_count = complete_val;
        status.in_progress    = series_open;
        return status;
    endfunction

    task automatic compare_field(string field, logic [COUNT_W-1:0] expected,
                                 logic [COUNT_W-1:0] actual);
        if (actual !== expected) begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", field, expected, actual);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wipe_map();
            count_base   = '0;
            frame_base   = '0;
            latest_val   = '0;
            complete_val = '0;
            series_open  = 1'b0;
            due_status_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_IDX_START) begin
                    count_base   = i_cfg.data;
                    latest_val   = i_cfg.data;
                    complete_val = i_cfg.data;
                end else if (i_cfg.index == CFG_IDX_REF) begin
                    frame_base = i_cfg.data;
                end
            end
            if (i_result.valid && i_result.ready) begin
                if (due_status_q.size() == 0) begin
                    mismatches++;
                    $error("status item with no event pending: latest_count %0d",
                           i_result.latest_count);
                end else begin
                    want = due_status_q.pop_front();
                    compare_field("latest_count", want.latest_count, i_result.latest_count);
                    compare_field("complete_count", want.complete_count,
                                  i_result.complete_count);
                    compare_field("in_progress", COUNT_W'(want.in_progress),
                                  COUNT_W'(i_result.in_progress));
                    compare_field("index_error", COUNT_W'(want.index_error),
                                  COUNT_W'(i_result.index_error));
                end
            end
            if (i_item.valid && i_item.ready) begin
                due_status_q = {due_status_q,
                                track_event(t_mode'(i_item.mode), i_item.frame_index)};
            end
        end
        o_pending_count <= due_status_q.size();
        o_fail_count    <= mismatches;
    end

endmodule

// ===== verif/frame_completion_tracker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Frame completion tracker testbench
// Drives directed and random frame events and register settings through
// phases of sender idling and receiver stalls, including a long receiver
// hold-off and a full drain pause; the checker beside the block predicts and
// compares every status item.
// ----------------------------------------------------------------------------
module frame_completion_tracker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fct_pkg::*;

    localparam int SLOTS           = DEF_FRAME_SLOTS;
    localparam int STALL_LIMIT     = 20000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_TAIL      = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;
    localparam logic [FRAME_W-1:0]   FRAME_MAX        = {FRAME_W{1'b1}};

    logic clk = 1'b0;
    logic rst_n;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int fail_count;
    int pending_count;
    int idle_cycles    = 0;
    int cursor         = 0;
    logic [FRAME_W-1:0] ref_setting = '0;

    fct_cfg_if    cfg_ch ();
    fct_item_if   item_ch ();
    fct_result_if result_ch ();

    frame_completion_tracker_unit #(
        .FRAME_SLOTS(SLOTS)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_item  (item_ch),
        .o_result(result_ch)
    );

    frame_completion_tracker_unit_checker #(
        .FRAME_SLOTS(SLOTS)
    ) i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg          (cfg_ch),
        .i_item         (item_ch),
        .i_result       (result_ch),
        .o_fail_count   (fail_count),
        .o_pending_count(pending_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n || (cfg_ch.valid && cfg_ch.ready) || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** frame_completion_tracker_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                result_ch.ready <= 1'b0;
                hold_cycles--;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [FRAME_W-1:0] rand_field();
        bit [31:0] word;
        word = $urandom();
        return word[FRAME_W-1:0];
    endfunction

    function automatic logic [FRAME_W-1:0] frame_from(longint unsigned offset);
        longint unsigned sum;
        sum = ref_setting + offset;
        return (sum > FRAME_MAX) ? FRAME_MAX : sum[FRAME_W-1:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_IDX_REF) begin
            ref_setting = value;
        end
    endtask

    task automatic send_event(t_mode mode, logic [FRAME_W-1:0] frame);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.mode        <= mode;
        item_ch.frame_index <= frame;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    task automatic new_settings();
        logic [CFG_DATA_W-1:0] value;
        case ($urandom_range(5))
            0:       value = '0;
            1:       value = COUNT_MAX;
            2:       value = CFG_DATA_W'(COUNT_MAX - $urandom_range(1100));
            default: value = CFG_DATA_W'($urandom_range(100000));
        endcase
        write_reg(CFG_IDX_START, value);
        case ($urandom_range(5))
            0:       value = '0;
            1:       value = FRAME_MAX - FRAME_W'(SLOTS - 1);
            2:       value = rand_field();
            default: value = CFG_DATA_W'($urandom_range(5000));
        endcase
        write_reg(CFG_IDX_REF, value);
    endtask

    task automatic send_random_events(int count);
        t_mode              mode;
        logic [FRAME_W-1:0] frame;
        int                 roll;
        int                 pick;
        for (int n = 0; n < count; n++) begin
            roll  = $urandom_range(99);
            frame = rand_field();
            if (roll < 3) begin
                mode   = MODE_START;
                cursor = 0;
            end else if (roll < 5) begin
                mode   = MODE_CLEAR;
                cursor = 0;
            end else if (roll < 10) begin
                mode = MODE_END;
            end else begin
                mode = MODE_MARK;
                pick = $urandom_range(99);
                if (pick < 75) begin
                    frame = frame_from(cursor + $urandom_range(3));
                    if ($urandom_range(1)) begin
                        cursor = (cursor + 1) % (SLOTS - 3);
                    end
                end else if (pick < 85) begin
                    frame = frame_from($urandom_range(SLOTS - 1));
                end else if (pick < 92) begin
                    if (ref_setting != 0) begin
                        frame = FRAME_W'($urandom_range(ref_setting - 1));
                    end
                end else if (pick < 96) begin
                    frame = frame_from(SLOTS + $urandom_range(3));
                end
            end
            send_event(mode, frame);
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        settle();
        new_settings();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        cursor         = 0;
        send_event(MODE_START, rand_field());
        send_random_events(count);
    endtask

    initial begin
        rst_n               <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_IDX_START;
        cfg_ch.data         <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.mode        <= MODE_MARK;
        item_ch.frame_index <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_IDX_START, '0);
        write_reg(CFG_IDX_REF, '0);
        write_reg(CFG_IDX_SPARE_LO, FRAME_MAX);
        write_reg(CFG_IDX_SPARE_HI, '0);

        send_event(MODE_START, '0);
        send_event(MODE_MARK, FRAME_W'(0));
        send_event(MODE_MARK, FRAME_W'(2));
        send_event(MODE_MARK, FRAME_W'(3));
        send_event(MODE_MARK, FRAME_W'(1));
        send_event(MODE_MARK, FRAME_W'(SLOTS - 1));
        send_event(MODE_MARK, FRAME_W'(SLOTS));
        send_event(MODE_MARK, FRAME_MAX);
        send_event(MODE_MARK, FRAME_W'(2));
        send_event(MODE_END, FRAME_MAX);
        send_event(MODE_CLEAR, '0);
        send_event(MODE_MARK, FRAME_W'(5));
        send_event(MODE_END, '0);
        settle();

        write_reg(CFG_IDX_REF, CFG_DATA_W'(100));
        write_reg(CFG_IDX_START, COUNT_MAX - CFG_DATA_W'(15));
        send_event(MODE_MARK, FRAME_W'(99));
        send_event(MODE_MARK, FRAME_W'(100));
        send_event(MODE_MARK, FRAME_W'(130));
        send_event(MODE_MARK, FRAME_W'(100 + SLOTS - 1));
        send_event(MODE_MARK, FRAME_W'(100 + SLOTS));
        settle();

        write_reg(CFG_IDX_START, COUNT_MAX);
        write_reg(CFG_IDX_REF, FRAME_MAX);
        send_event(MODE_START, FRAME_MAX);
        send_event(MODE_MARK, FRAME_MAX);
        send_event(MODE_MARK, '0);
        send_event(MODE_CLEAR, FRAME_MAX);

        run_phase(0, 0, 150);
        run_phase(71, 0, 150);
        run_phase(0, 71, 150);
        run_phase(11, 11, 150);

        run_phase(0, 0, 0);
        settle();
        hold_cycles = HOLD_OFF_CYCLES;
        send_random_events(60);
        settle();
        send_random_events(90);
        settle();

        repeat (DRAIN_TAIL) @(posedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("** frame_completion_tracker_unit: PASSED **");
        end else begin
            $display("** frame_completion_tracker_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/fct_pkg.sv
hdl/fct_item_if.sv
hdl/fct_result_if.sv
hdl/fct_cfg_if.sv
hdl/fct_queue.sv
hdl/fct_front.sv
hdl/fct_back.sv
hdl/frame_completion_tracker_unit.sv
verif/frame_completion_tracker_unit_checker.sv
verif/frame_completion_tracker_unit_tb.sv
